FILE: rtl/owbm_pkg.sv
// Shared types and constants of the one-wire bus master.
package owbm_pkg;

  // Request type codes carried with each tick.
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RESET_LOW   = 3'd0;
  localparam logic [2:0] CFG_PRES_SAMPLE = 3'd1;
  localparam logic [2:0] CFG_RECOVERY    = 3'd2;
  localparam logic [2:0] CFG_SHORT_LOW   = 3'd3;
  localparam logic [2:0] CFG_LONG_LOW    = 3'd4;
  localparam logic [2:0] CFG_READ_SAMPLE = 3'd5;
  localparam logic [2:0] CFG_SLOT_LEN    = 3'd6;

  // Register values after reset, in microseconds.
  localparam logic [9:0] RST_RESET_LOW   = 10'd480;
  localparam logic [7:0] RST_PRES_SAMPLE = 8'd70;
  localparam logic [9:0] RST_RECOVERY    = 10'd410;
  localparam logic [7:0] RST_SHORT_LOW   = 8'd6;
  localparam logic [7:0] RST_LONG_LOW    = 8'd60;
  localparam logic [7:0] RST_READ_SAMPLE = 8'd15;
  localparam logic [7:0] RST_SLOT_LEN    = 8'd70;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] tx_byte;
    logic       bus_in;
  } req_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       presence_level;
    logic       cmd_rejected;
  } rsp_t;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [7:0] presence_sample_time;
    logic [9:0] reset_recovery_time;
    logic [7:0] short_low_time;
    logic [7:0] long_low_time;
    logic [7:0] read_sample_time;
    logic [7:0] slot_length;
  } cfg_t;

endpackage

FILE: rtl/owbm_core.sv
// Bus sequencing state and the per-tick next-state and result logic.
module owbm_core #(
  parameter int COUNTER_BITS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  owbm_pkg::req_t  req_i,
  input  owbm_pkg::cfg_t  cfg_i,
  output owbm_pkg::rsp_t  rsp_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RESET = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;
  localparam logic [1:0] PH_READ  = 2'd3;

  // Compare width wide enough for both the counter and the 10-bit registers.
  localparam int XW = (COUNTER_BITS > 10) ? COUNTER_BITS : 10;
  localparam logic [XW-1:0] CNT_MAX = XW'((1 << COUNTER_BITS) - 1);

  logic [1:0]              phase_q, phase_d;
  logic [COUNTER_BITS-1:0] tick_q, tick_d;
  logic [2:0]              bit_q, bit_d;
  logic [7:0]              shift_q, shift_d;
  logic [7:0]              rcv_q, rcv_d;
  logic                    pres_q, pres_d;
  logic                    drive, done, rej;

  function automatic logic [XW-1:0] clamp_cnt(input logic [XW-1:0] v);
    clamp_cnt = (v > CNT_MAX) ? CNT_MAX : v;
  endfunction

  // Last tick index of a segment; a zero length counts as one tick.
  function automatic logic [XW-1:0] last_tick(input logic [9:0] len);
    logic [9:0] lt;
    lt = (len == 10'd0) ? 10'd0 : len - 10'd1;
    last_tick = clamp_cnt(XW'(lt));
  endfunction

  always_comb begin
    logic [XW-1:0] tk;
    logic [XW-1:0] endt;
    logic [XW-1:0] samp;
    logic [7:0]    low;
    logic [7:0]    samp8;
    logic [7:0]    pst;

    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    rcv_d   = rcv_q;
    pres_d  = pres_q;
    drive   = 1'b0;
    done    = 1'b0;
    rej     = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (req_i.req_type != owbm_pkg::REQ_NONE) begin
        case (req_i.req_type)
          owbm_pkg::REQ_RESET: phase_d = PH_RESET;
          owbm_pkg::REQ_WRITE: phase_d = PH_WRITE;
          default:             phase_d = PH_READ;
        endcase
        tick_d  = '0;
        bit_d   = 3'd0;
        shift_d = (req_i.req_type == owbm_pkg::REQ_WRITE) ? req_i.tx_byte : 8'd0;
      end
    end else if (req_i.req_type != owbm_pkg::REQ_NONE) begin
      rej = 1'b1;
    end

    tk    = XW'(tick_d);
    endt  = last_tick({2'b00, cfg_i.slot_length});
    pst   = (cfg_i.presence_sample_time == 8'd0) ? 8'd1 : cfg_i.presence_sample_time;
    samp8 = (cfg_i.read_sample_time == 8'd0) ? 8'd1 : cfg_i.read_sample_time;
    samp  = (XW'(samp8) > endt) ? endt : XW'(samp8);
    low   = 8'd1;

    case (phase_d)
      PH_RESET: begin
        // During a reset the bit index numbers the segment: low, release, recovery.
        if (bit_d == 3'd0) begin
          drive = 1'b1;
          if (tk >= last_tick(cfg_i.reset_low_time)) begin
            bit_d  = 3'd1;
            tick_d = '0;
          end else begin
            tick_d = tick_d + COUNTER_BITS'(1);
          end
        end else if (bit_d == 3'd1) begin
          if (tk >= clamp_cnt(XW'(pst))) begin
            pres_d = req_i.bus_in;
            bit_d  = 3'd2;
            tick_d = '0;
          end else begin
            tick_d = tick_d + COUNTER_BITS'(1);
          end
        end else begin
          if (tk >= last_tick(cfg_i.reset_recovery_time)) begin
            phase_d = PH_IDLE;
            bit_d   = 3'd0;
            tick_d  = '0;
            done    = 1'b1;
          end else begin
            tick_d = tick_d + COUNTER_BITS'(1);
          end
        end
      end
      PH_WRITE: begin
        low = shift_d[0] ? cfg_i.short_low_time : cfg_i.long_low_time;
        if (low == 8'd0) begin
          low = 8'd1;
        end
        drive = (tk < XW'(low));
        if (tk >= endt) begin
          shift_d = {1'b0, shift_d[7:1]};
          tick_d  = '0;
          if (bit_d == 3'd7) begin
            bit_d   = 3'd0;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            bit_d = bit_d + 3'd1;
          end
        end else begin
          tick_d = tick_d + COUNTER_BITS'(1);
        end
      end
      PH_READ: begin
        low = (cfg_i.short_low_time == 8'd0) ? 8'd1 : cfg_i.short_low_time;
        drive = (tk < XW'(low));
        if (tk == samp) begin
          shift_d = {req_i.bus_in, shift_d[7:1]};
        end
        if (tk >= endt) begin
          tick_d = '0;
          if (bit_d == 3'd7) begin
            bit_d   = 3'd0;
            phase_d = PH_IDLE;
            rcv_d   = shift_d;
            done    = 1'b1;
          end else begin
            bit_d = bit_d + 3'd1;
          end
        end else begin
          tick_d = tick_d + COUNTER_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_o.drive_low      = drive;
    rsp_o.busy_res       = (phase_d != PH_IDLE);
    rsp_o.done_res       = done;
    rsp_o.read_byte      = rcv_d;
    rsp_o.presence_level = pres_d;
    rsp_o.cmd_rejected   = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      rcv_q   <= 8'd0;
      pres_q  <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      rcv_q   <= rcv_d;
      pres_q  <= pres_d;
    end
  end

  ap_read_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RESET) |-> (bit_q <= 3'd2))
    else $error("reset sequence segment out of range");

  ap_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && done) |=> (phase_q == PH_IDLE))
    else $error("operation finished but sequencer not idle");

  ap_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && rej) |-> (phase_q != PH_IDLE))
    else $error("command rejected while idle");

endmodule

FILE: rtl/onewire_bus_master.sv
// One-wire bus master top level: configuration registers and result register.
//
// Usage: every request on the req channel is one microsecond tick. It carries
// an optional command (reset pulse, write byte, read byte) and the line level
// sampled during that tick. Each accepted request yields exactly one response
// on the rsp channel with the line drive for the tick, busy, done, the last
// byte read, the last presence level and a flag for a command that arrived
// while an operation was running (such a command is dropped).
// Latency: the response is valid the cycle after its request is accepted.
// Throughput: one request per cycle unless the receiver stalls; the
// sequencer state and the response are computed in one pass of logic
// between the request port and the response register.
// When the receiver stalls, the response is held and req_ready_o drops
// until it is taken; a request is accepted in the same cycle the held response
// leaves. Configuration is written on the cfg channel (always ready); the
// user must do so only while idle; the block does not enforce it. Reset
// returns all timing registers to their defaults (480/70/410/6/60/15/70 us),
// the sequencer to idle and the presence level to one.
module onewire_bus_master #(
  parameter int COUNTER_BITS = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  owbm_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output owbm_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [9:0]     cfg_data_i
);

  owbm_pkg::cfg_t cfg_q;
  owbm_pkg::rsp_t rsp_d, rsp_q;
  logic           rsp_valid_q;
  logic           step;

  assign cfg_ready_o = 1'b1;
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign step        = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time       <= owbm_pkg::RST_RESET_LOW;
      cfg_q.presence_sample_time <= owbm_pkg::RST_PRES_SAMPLE;
      cfg_q.reset_recovery_time  <= owbm_pkg::RST_RECOVERY;
      cfg_q.short_low_time       <= owbm_pkg::RST_SHORT_LOW;
      cfg_q.long_low_time        <= owbm_pkg::RST_LONG_LOW;
      cfg_q.read_sample_time     <= owbm_pkg::RST_READ_SAMPLE;
      cfg_q.slot_length          <= owbm_pkg::RST_SLOT_LEN;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        owbm_pkg::CFG_RESET_LOW:   cfg_q.reset_low_time       <= cfg_data_i;
        owbm_pkg::CFG_PRES_SAMPLE: cfg_q.presence_sample_time <= cfg_data_i[7:0];
        owbm_pkg::CFG_RECOVERY:    cfg_q.reset_recovery_time  <= cfg_data_i;
        owbm_pkg::CFG_SHORT_LOW:   cfg_q.short_low_time       <= cfg_data_i[7:0];
        owbm_pkg::CFG_LONG_LOW:    cfg_q.long_low_time        <= cfg_data_i[7:0];
        owbm_pkg::CFG_READ_SAMPLE: cfg_q.read_sample_time     <= cfg_data_i[7:0];
        owbm_pkg::CFG_SLOT_LEN:    cfg_q.slot_length          <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  owbm_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .rsp_o  (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_ready_o) begin
      rsp_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  ap_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.done_res) |-> !rsp_o.busy_res)
    else $error("response reports done and busy together");

  ap_drive_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.drive_low) |-> (rsp_o.busy_res || rsp_o.done_res))
    else $error("line driven low outside an operation");

  ap_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> rsp_valid_o)
    else $error("accepted request produced no response");

  ap_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |-> !req_ready_o)
    else $error("request accepted while response stalled");

endmodule
